// ===== hdl/rpid_pkg.sv =====
// Package for the rate PID controller: fixed-point constants, the arithmetic
// operation codes of the shared unit and its command/status structs.
// No dependencies.
package rpid_pkg;

   localparam int FracBits = 16;
   localparam logic signed [31:0] OneQ = 32'sd65536;
   localparam logic signed [31:0] FloorQ = 32'sd13107;
   localparam logic [16:0] FilterAlpha = 17'd45875;
   localparam logic [16:0] FilterBeta = 17'd65536 - FilterAlpha;
   localparam logic signed [63:0] I32Max = 64'sd2147483647;
   localparam logic signed [63:0] I32Min = -64'sd2147483648;

   // Configuration register indexes.
   localparam logic [2:0] RegPropGain = 3'd0;
   localparam logic [2:0] RegIntegGain = 3'd1;
   localparam logic [2:0] RegDerivGain = 3'd2;
   localparam logic [2:0] RegFfGain = 3'd3;
   localparam logic [2:0] RegIntegLimit = 3'd4;
   localparam logic [2:0] RegOutLimit = 3'd5;
   localparam logic [2:0] RegAttenRate = 3'd6;
   localparam logic [2:0] RegAttenBreak = 3'd7;

   // Operations of the shared arithmetic unit.
   typedef enum logic [0:0] {
      OP_MUL,
      OP_DIV
   } op_type;

   typedef struct packed {
      logic              start;
      op_type            op;
      logic signed [32:0] a;
      logic signed [32:0] b;
   } au_cmd_type;

   typedef struct packed {
      logic              done;
      logic signed [31:0] result;
   } au_sts_type;

   // Saturate a 64-bit signed value to the 32-bit range.
   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      logic signed [31:0] r;
      if (v > I32Max) r = 32'sh7FFFFFFF;
      else if (v < I32Min) r = 32'sh80000000;
      else r = v[31:0];
      return r;
   endfunction

endpackage

// ===== hdl/rate_pid_with_tpa_feedforward.sv =====
// Top level of the rate PID controller with throttle attenuation and
// feedforward. Depends on rpid_pkg and rpid_arith.
//
// One request is one control tick and gives one response. Work is done by a
// single shared multiply/divide unit under a sequencer; the unit divides by a
// 64-step restoring division. Each tick issues its P, I and D operations in
// turn, with a divide and a multiply more when throttle attenuation is active
// and a divide and a multiply more when feedforward is on; a tick with a step
// time of zero or less skips the arithmetic and answers from the check state.
// The block takes no new request until the response has been accepted, and
// the next request is taken in the cycle after that at the earliest.
module rate_pid_with_tpa_feedforward (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic signed [31:0] req_target_rate,
   input  logic signed [31:0] req_gyro_rate,
   input  logic signed [31:0] req_step_time,
   input  logic [16:0] req_throttle,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic signed [31:0] rsp_drive,
   output logic signed [31:0] rsp_p_part,
   output logic signed [31:0] rsp_i_part,
   output logic signed [31:0] rsp_d_part,
   output logic signed [31:0] rsp_ff_part
);
   import rpid_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE, S_CHECK, S_PROG, S_FACT, S_PF, S_P, S_IE, S_INC, S_IACC,
      S_DM, S_DF, S_RAW, S_FILT, S_FFD, S_FF, S_SUM, S_OUT
   } state_type;

   state_type state_ff;
   logic busy_ff;
   logic signed [31:0] kp_ff, ki_ff, kd_ff, kf_ff;
   logic [30:0] ilim_ff, olim_ff;
   logic [17:0] arate_ff;
   logic [16:0] abrk_ff;
   logic signed [31:0] integ_ff, lgyro_ff, ltgt_ff, filt_ff, ldrive_ff;
   logic first_ff;
   logic signed [31:0] tgt_ff, gyro_ff, dt_ff, err_ff, fac_ff, tmp_ff;
   logic [16:0] thr_ff;
   logic signed [31:0] p_ff, ffv_ff;
   logic rsp_valid_ff;
   logic signed [31:0] o_drive_ff, o_p_ff, o_i_ff, o_d_ff, o_ff_ff;
   au_cmd_type cmd;
   au_sts_type sts;

   logic signed [63:0] isum, fsum, tot;
   logic signed [31:0] icl, tcl, raw_neg, fac_new;
   logic signed [31:0] prog_cap;

   rpid_arith u_arith (.clock(clock), .reset(reset), .cmd(cmd), .sts(sts));

   // Command to the shared unit, issued on entry to each arithmetic state.
   always_comb begin
      cmd.start = 1'b0;
      cmd.op = OP_MUL;
      cmd.a = '0;
      cmd.b = '0;
      if (!busy_ff) begin
         case (state_ff)
            S_PROG: begin
               cmd.start = 1'b1; cmd.op = OP_DIV;
               cmd.a = 33'($signed({1'b0, thr_ff}) - $signed({1'b0, abrk_ff}));
               cmd.b = 33'(OneQ) - $signed({16'd0, abrk_ff});
            end
            S_FACT: begin
               cmd.start = 1'b1; cmd.a = $signed({15'd0, arate_ff}); cmd.b = 33'(prog_cap);
            end
            S_PF: begin cmd.start = 1'b1; cmd.a = 33'(kp_ff); cmd.b = 33'(fac_ff); end
            S_P: begin cmd.start = 1'b1; cmd.a = 33'(tmp_ff); cmd.b = 33'(err_ff); end
            S_IE: begin cmd.start = 1'b1; cmd.a = 33'(err_ff); cmd.b = 33'(ki_ff); end
            S_INC: begin cmd.start = 1'b1; cmd.a = 33'(tmp_ff); cmd.b = 33'(dt_ff); end
            S_DM: begin
               cmd.start = 1'b1; cmd.op = OP_DIV;
               cmd.a = 33'(gyro_ff) - 33'(lgyro_ff); cmd.b = 33'(dt_ff);
            end
            S_DF: begin cmd.start = 1'b1; cmd.a = 33'(kd_ff); cmd.b = 33'(fac_ff); end
            S_RAW: begin cmd.start = 1'b1; cmd.a = 33'(tmp_ff); cmd.b = 33'(ffv_ff); end
            S_FFD: begin
               cmd.start = 1'b1; cmd.op = OP_DIV;
               cmd.a = 33'(tgt_ff) - 33'(ltgt_ff); cmd.b = 33'(dt_ff);
            end
            S_FF: begin cmd.start = 1'b1; cmd.a = 33'(kf_ff); cmd.b = 33'(tmp_ff); end
            default: cmd.start = 1'b0;
         endcase
      end
   end

   // Small datapath pieces outside the shared unit.
   always_comb begin
      prog_cap = (tmp_ff > OneQ) ? OneQ : tmp_ff;
      fac_new = OneQ - sts.result;
      if (fac_new < FloorQ) fac_new = FloorQ;
      isum = 64'(integ_ff) + 64'(sts.result);
      icl = sat32(isum);
      if (icl > $signed({1'b0, ilim_ff})) icl = $signed({1'b0, ilim_ff});
      else if (icl < -$signed({1'b0, ilim_ff})) icl = -$signed({1'b0, ilim_ff});
      raw_neg = sat32(-64'(sts.result));
      fsum = 64'(FilterAlpha) * 64'(filt_ff) + 64'(FilterBeta) * 64'(tmp_ff)
             + 64'sd32768;
      tot = 64'(p_ff) + 64'(integ_ff) + 64'(filt_ff) + 64'(ffv_ff);
      tcl = sat32(tot);
      if (tcl > $signed({1'b0, olim_ff})) tcl = $signed({1'b0, olim_ff});
      else if (tcl < -$signed({1'b0, olim_ff})) tcl = -$signed({1'b0, olim_ff});
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         kp_ff <= '0; ki_ff <= '0; kd_ff <= '0; kf_ff <= '0;
         ilim_ff <= 31'd19660800; olim_ff <= 31'd26214400;
         arate_ff <= '0; abrk_ff <= 17'd32768;
      end else if (csr_we) begin
         case (csr_index)
            RegPropGain: kp_ff <= csr_wdata;
            RegIntegGain: ki_ff <= csr_wdata;
            RegDerivGain: kd_ff <= csr_wdata;
            RegFfGain: kf_ff <= csr_wdata;
            RegIntegLimit: ilim_ff <= csr_wdata[30:0];
            RegOutLimit: olim_ff <= csr_wdata[30:0];
            RegAttenRate: arate_ff <= csr_wdata[17:0];
            RegAttenBreak: abrk_ff <= csr_wdata[16:0];
            default: ;
         endcase
      end
   end

   // Tick sequencer; busy_ff marks a command waiting on the shared unit.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         busy_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         integ_ff <= '0; lgyro_ff <= '0; ltgt_ff <= '0;
         filt_ff <= '0; ldrive_ff <= '0; first_ff <= 1'b1;
      end else begin
         if (cmd.start) busy_ff <= 1'b1;
         else if (sts.done) busy_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  tgt_ff <= req_target_rate; gyro_ff <= req_gyro_rate;
                  dt_ff <= req_step_time; thr_ff <= req_throttle;
                  state_ff <= S_CHECK;
               end
            end
            S_CHECK: begin
               fac_ff <= OneQ;
               err_ff <= sat32(64'(tgt_ff) - 64'(gyro_ff));
               ffv_ff <= '0;
               if (dt_ff <= 0) begin
                  o_drive_ff <= ldrive_ff; o_p_ff <= '0; o_i_ff <= '0;
                  o_d_ff <= '0; o_ff_ff <= '0;
                  state_ff <= S_OUT;
                  rsp_valid_ff <= 1'b1;
               end else begin
                  if (first_ff) begin
                     lgyro_ff <= gyro_ff; ltgt_ff <= tgt_ff; first_ff <= 1'b0;
                  end
                  if (arate_ff != '0 && thr_ff > abrk_ff && abrk_ff < 17'd65536)
                     state_ff <= S_PROG;
                  else state_ff <= S_PF;
               end
            end
            S_PROG: if (sts.done) begin tmp_ff <= sts.result; state_ff <= S_FACT; end
            S_FACT: if (sts.done) begin fac_ff <= fac_new; state_ff <= S_PF; end
            S_PF: if (sts.done) begin tmp_ff <= sts.result; state_ff <= S_P; end
            S_P: if (sts.done) begin p_ff <= sts.result; state_ff <= S_IE; end
            S_IE: if (sts.done) begin tmp_ff <= sts.result; state_ff <= S_INC; end
            S_INC: if (sts.done) begin integ_ff <= icl; state_ff <= S_DM; end
            S_DM: if (sts.done) begin ffv_ff <= sts.result; state_ff <= S_DF; end
            S_DF: if (sts.done) begin tmp_ff <= sts.result; state_ff <= S_RAW; end
            S_RAW: if (sts.done) begin
               tmp_ff <= raw_neg; ffv_ff <= '0; state_ff <= S_FILT;
            end
            S_FILT: begin
               filt_ff <= sat32(fsum >>> 16);
               state_ff <= (kf_ff > 0) ? S_FFD : S_SUM;
            end
            S_FFD: if (sts.done) begin tmp_ff <= sts.result; state_ff <= S_FF; end
            S_FF: if (sts.done) begin ffv_ff <= sts.result; state_ff <= S_SUM; end
            S_SUM: begin
               ldrive_ff <= tcl; lgyro_ff <= gyro_ff; ltgt_ff <= tgt_ff;
               o_drive_ff <= tcl; o_p_ff <= p_ff; o_i_ff <= integ_ff;
               o_d_ff <= filt_ff; o_ff_ff <= ffv_ff;
               rsp_valid_ff <= 1'b1;
               state_ff <= S_OUT;
            end
            S_OUT: if (!rsp_stall) begin
               rsp_valid_ff <= 1'b0;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_drive = o_drive_ff;
   assign rsp_p_part = o_p_ff;
   assign rsp_i_part = o_i_ff;
   assign rsp_d_part = o_d_ff;
   assign rsp_ff_part = o_ff_ff;

endmodule

// ===== hdl/rpid_arith.sv =====
// Shared arithmetic unit of the rate PID controller: a signed fixed-point
// multiplier (partial products over the low and high slices of b) and a radix-2 divider.
// Depends on rpid_pkg.
module rpid_arith (
   input  logic                clock,
   input  logic                reset,
   input  rpid_pkg::au_cmd_type cmd,
   output rpid_pkg::au_sts_type sts
);
   import rpid_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_MUL_LO,
      S_MUL_HI,
      S_MUL_FIN,
      S_DIV,
      S_DIV_FIN
   } state_type;

   state_type state_ff;
   logic signed [32:0] a_ff;
   logic signed [32:0] b_ff;
   logic signed [65:0] acc_ff;
   logic [63:0] rem_ff;
   logic [63:0] quo_ff;
   logic [63:0] divr_ff;
   logic neg_ff;
   logic [5:0] cnt_ff;
   logic done_ff;
   logic signed [31:0] res_ff;

   logic [64:0] trial;
   logic [63:0] rem_sh;
   logic signed [65:0] rnd;
   logic signed [65:0] shifted;
   logic signed [50:0] pp;
   logic [63:0] num_abs;
   logic signed [63:0] num_s;

   // Final quotient bit, sign and saturation of a division.
   function automatic logic signed [31:0] div_result(input logic [63:0] q,
                                                      input logic tb,
                                                      input logic ng);
      logic [63:0] m;
      logic signed [64:0] s;
      m = {q[62:0], ~tb};
      s = ng ? -$signed({1'b0, m}) : $signed({1'b0, m});
      if (s > 65'(I32Max)) return 32'sh7FFFFFFF;
      if (s < 65'(I32Min)) return 32'sh80000000;
      return s[31:0];
   endfunction

   // Partial product: signed a times one 17-bit slice of b (low slice unsigned).
   always_comb begin
      if (state_ff == S_MUL_LO) begin
         pp = a_ff * $signed({1'b0, b_ff[15:0]});
      end else begin
         pp = a_ff * $signed(b_ff[32:16]);
      end
   end

   // One restoring division step on the magnitude of the numerator.
   always_comb begin
      rem_sh = {rem_ff[62:0], quo_ff[63]};
      trial = {1'b0, rem_sh} - {1'b0, divr_ff};
   end

   // Rounding of the product, ties toward plus infinity.
   always_comb begin
      rnd = acc_ff + 66'sd32768;
      shifted = rnd >>> FracBits;
      num_s = 64'(a_ff) <<< FracBits;
      num_abs = num_s[63] ? 64'(-num_s) : 64'(num_s);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         done_ff <= 1'b0;
      end else begin
         done_ff <= (state_ff == S_MUL_FIN) || (state_ff == S_DIV_FIN);
         case (state_ff)
            S_IDLE: begin
               if (cmd.start) begin
                  a_ff <= cmd.a;
                  b_ff <= cmd.b;
                  acc_ff <= '0;
                  state_ff <= (cmd.op == OP_MUL) ? S_MUL_LO : S_DIV;
                  neg_ff <= cmd.a[32] ^ cmd.b[32];
                  cnt_ff <= '0;
                  rem_ff <= '0;
                  divr_ff <= cmd.b[32] ? 64'(-cmd.b) : 64'(cmd.b);
                  quo_ff <= '0;
               end
            end
            S_MUL_LO: begin
               acc_ff <= 66'(pp);
               state_ff <= S_MUL_HI;
            end
            S_MUL_HI: begin
               acc_ff <= acc_ff + (66'(pp) <<< 16);
               state_ff <= S_MUL_FIN;
            end
            S_MUL_FIN: begin
               res_ff <= sat32(shifted[63:0]);
               state_ff <= S_IDLE;
            end
            S_DIV: begin
               if (cnt_ff == 6'd0) begin
                  quo_ff <= num_abs;
                  rem_ff <= '0;
                  cnt_ff <= 6'd1;
               end else begin
                  if (!trial[64]) begin
                     rem_ff <= trial[63:0];
                     quo_ff <= {quo_ff[62:0], 1'b1};
                  end else begin
                     rem_ff <= rem_sh;
                     quo_ff <= {quo_ff[62:0], 1'b0};
                  end
                  if (cnt_ff == 6'd63) state_ff <= S_DIV_FIN;
                  cnt_ff <= cnt_ff + 6'd1;
               end
            end
            S_DIV_FIN: begin
               // Last of the 64 quotient bits is formed here.
               if (!trial[64]) quo_ff <= {quo_ff[62:0], 1'b1};
               else quo_ff <= {quo_ff[62:0], 1'b0};
               state_ff <= S_IDLE;
               res_ff <= div_result(quo_ff, trial[64], neg_ff);
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign sts.done = done_ff;
   assign sts.result = res_ff;

endmodule

// ===== hdl/rpid_checker.sv =====
// Port-level checker for the rate PID controller, bound to the top level.
// Depends on rate_pid_with_tpa_feedforward's ports only.
module rpid_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic signed [31:0] rsp_drive
);
   // A stalled response keeps its drive value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_drive))
      else $error("response changed while stalled");

   // No request is taken while a response is pending.
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("request accepted while response pending");

   // A request accepted means no response appears the next cycle.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> !rsp_valid)
      else $error("response too early");
endmodule

bind rate_pid_with_tpa_feedforward rpid_checker u_rpid_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_drive(rsp_drive)
);

// ===== bench/tb_rate_pid_with_tpa_feedforward.sv =====
`timescale 1ns / 100ps
// Self-checking bench for the rate PID controller with throttle attenuation and
// feedforward. Depends on rpid_pkg and the rate_pid_with_tpa_feedforward RTL.
module tb_rate_pid_with_tpa_feedforward;
   import rpid_pkg::*;

   localparam int WatchdogLimit = 6000;

   typedef struct {
      logic signed [31:0] target;
      logic signed [31:0] gyro;
      logic signed [31:0] step;
      logic [16:0]        throttle;
   } tick_type;

   typedef struct {
      logic signed [31:0] drive;
      logic signed [31:0] p_part;
      logic signed [31:0] i_part;
      logic signed [31:0] d_part;
      logic signed [31:0] ff_part;
   } drive_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [2:0] csr_index = RegPropGain;
   logic [31:0] csr_wdata = '0;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [31:0] req_target_rate = '0;
   logic signed [31:0] req_gyro_rate = '0;
   logic signed [31:0] req_step_time = '0;
   logic [16:0] req_throttle = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [31:0] rsp_drive, rsp_p_part, rsp_i_part, rsp_d_part, rsp_ff_part;

   rate_pid_with_tpa_feedforward i_dut (.*);

   always #10 clock = ~clock;

   // Controller settings and state as the predictor sees them.
   longint k_prop, k_integ, k_deriv, k_ff, lim_integ, lim_out, att_rate, att_break;
   longint integ_acc, prev_gyro, prev_target, deriv_filt, prev_drive;
   bit primed;

   drive_type expected_drives[$];
   int errors = 0;
   int ticks_sent = 0;
   int drives_seen = 0;
   int snd_idle = 0;
   int rcv_idle = 0;
   int hold_request = 0;

   function automatic longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   // Round to nearest with ties upward; an arithmetic shift floors.
   function automatic longint round_q(longint v);
      return (v + 64'sd32768) >>> FracBits;
   endfunction

   function automatic longint qmul(longint a, longint b);
      return clamp32(round_q(a * b));
   endfunction

   function automatic longint qdiv(longint a, longint d);
      return clamp32((a * 64'sd65536) / d);
   endfunction

   function automatic void set_reg(logic [2:0] idx, logic [31:0] v);
      case (idx)
         RegPropGain:   k_prop = longint'(signed'(v));
         RegIntegGain:  k_integ = longint'(signed'(v));
         RegDerivGain:  k_deriv = longint'(signed'(v));
         RegFfGain:     k_ff = longint'(signed'(v));
         RegIntegLimit: lim_integ = longint'(v[30:0]);
         RegOutLimit:   lim_out = longint'(v[30:0]);
         RegAttenRate:  att_rate = longint'(v[17:0]);
         RegAttenBreak: att_break = longint'(v[16:0]);
         default: ;
      endcase
   endfunction

   // One control tick: attenuation, P, clamped I, filtered D on measurement, FF.
   function automatic drive_type pid_tick(tick_type t);
      drive_type r;
      longint tgt, gyr, dt, thr, factor, prog, err, p, inc, dmeas, raw, ff, sum;
      tgt = longint'(t.target);
      gyr = longint'(t.gyro);
      dt = longint'(t.step);
      thr = longint'(t.throttle);
      // A hold tick repeats the last drive and leaves the state alone.
      if (dt <= 0) begin
         r.drive = prev_drive[31:0];
         r.p_part = '0;
         r.i_part = '0;
         r.d_part = '0;
         r.ff_part = '0;
         return r;
      end
      factor = 65536;
      if (att_rate > 0 && thr > att_break && att_break < 65536) begin
         prog = qdiv(thr - att_break, 65536 - att_break);
         if (prog > 65536) prog = 65536;
         factor = 65536 - qmul(att_rate, prog);
         if (factor < longint'(FloorQ)) factor = longint'(FloorQ);
      end
      err = clamp32(tgt - gyr);
      if (primed) begin
         prev_gyro = gyr;
         prev_target = tgt;
         primed = 1'b0;
      end
      p = qmul(qmul(k_prop, factor), err);
      inc = qmul(qmul(err, k_integ), dt);
      integ_acc = clamp32(integ_acc + inc);
      if (integ_acc > lim_integ) integ_acc = lim_integ;
      else if (integ_acc < -lim_integ) integ_acc = -lim_integ;
      dmeas = qdiv(gyr - prev_gyro, dt);
      raw = clamp32(-qmul(qmul(k_deriv, factor), dmeas));
      deriv_filt = clamp32(round_q(longint'(FilterAlpha) * deriv_filt +
                                   longint'(FilterBeta) * raw));
      ff = 0;
      if (k_ff > 0) ff = qmul(k_ff, qdiv(tgt - prev_target, dt));
      sum = clamp32(p + integ_acc + deriv_filt + ff);
      if (sum > lim_out) sum = lim_out;
      else if (sum < -lim_out) sum = -lim_out;
      prev_drive = sum;
      prev_gyro = gyr;
      prev_target = tgt;
      r.drive = sum[31:0];
      r.p_part = p[31:0];
      r.i_part = integ_acc[31:0];
      r.d_part = deriv_filt[31:0];
      r.ff_part = ff[31:0];
      return r;
   endfunction

   // Receiver: checks each accepted response and stalls at random or on demand.
   int hold_left = 0;
   always @(posedge clock) begin
      drive_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         drives_seen++;
         if (expected_drives.size() == 0) begin
            $error("response with no request outstanding: drive %0d", rsp_drive);
            errors++;
         end else begin
            e = expected_drives.pop_front();
            if (rsp_drive !== e.drive) begin
               $error("drive: expected %0d, got %0d", e.drive, rsp_drive);
               errors++;
            end
            if (rsp_p_part !== e.p_part) begin
               $error("p_part: expected %0d, got %0d", e.p_part, rsp_p_part);
               errors++;
            end
            if (rsp_i_part !== e.i_part) begin
               $error("i_part: expected %0d, got %0d", e.i_part, rsp_i_part);
               errors++;
            end
            if (rsp_d_part !== e.d_part) begin
               $error("d_part: expected %0d, got %0d", e.d_part, rsp_d_part);
               errors++;
            end
            if (rsp_ff_part !== e.ff_part) begin
               $error("ff_part: expected %0d, got %0d", e.ff_part, rsp_ff_part);
               errors++;
            end
         end
      end
      if (hold_request > 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rcv_idle);
      end
   end

   // Watchdog on cycles without any handshake.
   int quiet_cycles = 0;
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WatchdogLimit) begin
         $display("status: fail");
         $finish;
      end
   end

   // Offers one request and returns at the edge where it is accepted.
   task automatic send_tick(tick_type t);
      int gap;
      if ($urandom_range(99) < snd_idle) begin
         req_valid <= 1'b0;
         gap = $urandom_range(1, 6);
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_target_rate <= t.target;
      req_gyro_rate <= t.gyro;
      req_step_time <= t.step;
      req_throttle <= t.throttle;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_drives.push_back(pid_tick(t));
      ticks_sent++;
   endtask

   // Stops offering and waits until every response has come back.
   task automatic drain;
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_drives.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Writes all eight registers back to back; the block must be idle.
   task automatic configure(logic [31:0] vals[8]);
      for (int i = 0; i < 8; i++) begin
         csr_we <= 1'b1;
         csr_index <= i[2:0];
         csr_wdata <= vals[i];
         set_reg(i[2:0], vals[i]);
         @(posedge clock);
      end
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   function automatic tick_type make_tick(logic signed [31:0] tg, logic signed [31:0] gy,
                                          logic signed [31:0] st, logic [16:0] th);
      tick_type t;
      t.target = tg;
      t.gyro = gy;
      t.step = st;
      t.throttle = th;
      return t;
   endfunction

   // Mostly plausible flight values, with holds, extremes and raw bit patterns.
   function automatic tick_type random_tick();
      tick_type t;
      int sel;
      sel = $urandom_range(99);
      t.target = $signed($urandom_range(0, 32'h0800_0000)) - 32'sh0400_0000;
      t.gyro = t.target + $signed($urandom_range(0, 32'h0100_0000)) - 32'sh0080_0000;
      t.step = $urandom_range(1, 4000);
      t.throttle = 17'($urandom_range(0, 65536));
      if (sel < 5) t.step = -$signed($urandom_range(0, 100));
      else if (sel < 12) begin
         t.target = $urandom;
         t.gyro = $urandom;
         t.step = $urandom;
         t.throttle = 17'($urandom);
      end else if (sel < 16) begin
         t.target = $urandom_range(1) ? 32'sh7FFFFFFF : 32'sh80000000;
         t.gyro = $urandom_range(1) ? 32'sh7FFFFFFF : 32'sh80000000;
         t.step = $urandom_range(1) ? 32'sd1 : 32'sh7FFFFFFF;
      end
      return t;
   endfunction

   function automatic logic [31:0] random_gain();
      case ($urandom_range(4))
         0: return 32'd0;
         1: return $urandom;
         2: return $urandom_range(1) ? 32'h7FFFFFFF : 32'h80000000;
         default: return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
      endcase
   endfunction

   function automatic logic [31:0] random_limit();
      case ($urandom_range(4))
         0: return 32'd0;
         1: return 32'h7FFFFFFF;
         2: return $urandom;
         default: return $urandom_range(0, 32'h0200_0000);
      endcase
   endfunction

   task automatic random_settings;
      logic [31:0] v[8];
      v[RegPropGain] = random_gain();
      v[RegIntegGain] = random_gain();
      v[RegDerivGain] = random_gain();
      v[RegFfGain] = random_gain();
      v[RegIntegLimit] = random_limit();
      v[RegOutLimit] = random_limit();
      v[RegAttenRate] = $urandom_range(3) == 0 ? $urandom : $urandom_range(0, 131072);
      v[RegAttenBreak] = $urandom_range(3) == 0 ? $urandom : $urandom_range(0, 65536);
      configure(v);
   endtask

   // Reset settings: priming on the first tick with a positive step, and hold ticks, with zero gains.
   task automatic test_reset_settings;
      send_tick(make_tick(32'sd0, 32'sd0, 32'sd0, 17'd0));
      send_tick(make_tick(32'sd655360, -32'sd65536, 32'sd65, 17'd65536));
      send_tick(make_tick(32'sd100, 32'sd200, -32'sd1, 17'd0));
      drain();
   endtask

   // Directed extremes: attenuation floor, breakpoint edges, clamps, FF on and off.
   task automatic test_directed;
      logic [31:0] v[8];
      v = '{32'h0001_8000, 32'h0000_8000, 32'h0000_4000, 32'h0000_2000,
            32'h0064_0000, 32'h00C8_0000, 32'd131072, 32'd16384};
      configure(v);
      send_tick(make_tick(32'sd6553600, 32'sd0, 32'sd65, 17'd65536));
      send_tick(make_tick(32'sh7FFFFFFF, 32'sh80000000, 32'sd1, 17'd131071));
      send_tick(make_tick(32'sh80000000, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 17'd0));
      send_tick(make_tick(32'sd1000, 32'sd5000, 32'sh80000000, 17'd40000));
      send_tick(make_tick(32'sd0, -32'sd6553600, 32'sd1, 17'd16385));
      drain();
      v = '{32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h80000000,
            32'h0, 32'h7FFFFFFF, 32'd65536, 32'd65536};
      configure(v);
      send_tick(make_tick(32'sh7FFFFFFF, 32'sh80000000, 32'sd1, 17'd65536));
      send_tick(make_tick(32'sh80000000, 32'sh7FFFFFFF, 32'sd2, 17'd131071));
      send_tick(make_tick(32'sd12345, -32'sd54321, 32'sd0, 17'd65536));
      drain();
      v = '{32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF,
            32'h7FFFFFFF, 32'h0, 32'd262143, 32'd0};
      configure(v);
      send_tick(make_tick(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sd1, 17'd1));
      send_tick(make_tick(32'sh80000000, 32'sh7FFFFFFF, 32'sd1, 17'd65536));
      send_tick(make_tick(32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF, 17'd131071));
      v = '{32'h0002_0000, 32'h0001_0000, 32'h0000_1000, 32'h0001_0000,
            32'h7FFFFFFF, 32'h7FFFFFFF, 32'd0, 32'd131071};
      drain();
      configure(v);
      send_tick(make_tick(32'sd65536000, 32'sd0, 32'sd655, 17'd65536));
      send_tick(make_tick(-32'sd65536000, 32'sd3276800, 32'sd655, 17'd0));
      send_tick(make_tick(32'sd0, 32'sd0, -32'sd65536, 17'd0));
      drain();
   endtask

   // Random ticks under one idling pattern, reconfiguring from idle now and then.
   task automatic test_random_phase(int n, int s_idle, int r_idle);
      snd_idle = s_idle;
      rcv_idle = r_idle;
      for (int i = 0; i < n; i++) begin
         if (i % 95 == 0) begin
            drain();
            random_settings();
         end
         send_tick(random_tick());
      end
      drain();
   endtask

   // Response side held off for a long stretch while requests keep coming.
   task automatic test_backpressure;
      snd_idle = 0;
      hold_request = 900;
      for (int i = 0; i < 6; i++) send_tick(random_tick());
      drain();
   endtask

   initial begin
      k_prop = 0; k_integ = 0; k_deriv = 0; k_ff = 0;
      lim_integ = 19660800; lim_out = 26214400; att_rate = 0; att_break = 32768;
      integ_acc = 0; prev_gyro = 0; prev_target = 0; deriv_filt = 0; prev_drive = 0;
      primed = 1'b1;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_settings();
      test_directed();
      test_backpressure();
      test_random_phase(575, 14, 51);
      test_random_phase(575, 51, 14);
      test_random_phase(575, 0, 0);
      repeat (400) @(posedge clock);
      if (expected_drives.size() != 0) begin
         $error("%0d responses never arrived", expected_drives.size());
         errors++;
      end
      $display("Sent %0d control ticks and checked %0d responses over random gains,",
               ticks_sent, drives_seen);
      $display("limits, attenuation settings, hold ticks and stalls on both sides.");
      if (errors == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end
endmodule

// ===== rate_pid_with_tpa_feedforward.f =====
hdl/rpid_pkg.sv
hdl/rpid_arith.sv
hdl/rate_pid_with_tpa_feedforward.sv
hdl/rpid_checker.sv
bench/tb_rate_pid_with_tpa_feedforward.sv
